// ===== rtl/cansx_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - shared package
// Types, widths and codes shared by the front end, the queue, the back end
// and the top level.
// ----------------------------------------------------------------------------
package cansx_pkg;

    // Field widths
    localparam int ID_W      = 29;
    localparam int DATA_W    = 64;
    localparam int COUNT_W   = 4;
    localparam int START_W   = 6;
    localparam int LEN_W     = 7;
    localparam int FACTOR_W  = 32;
    localparam int OFFSET_W  = 64;
    localparam int RAW_W     = DATA_W + 1;
    localparam int DATA_BYTES = 8;

    // Configuration port
    localparam int ADDR_W    = 6;
    localparam int PDATA_W   = 64;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Longest signal in bits
    localparam logic [LEN_W-1:0] LEN_MAX = 7'd64;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ID_MISMATCH  = 2'd1,
        ST_BEYOND_FRAME = 2'd2
    } status_t;

    // Register indexes (byte address is 8 times the index)
    typedef enum logic [2:0] {
        REG_MESSAGE_ID   = 3'd0,
        REG_SIG_START    = 3'd1,
        REG_BIT_LENGTH   = 3'd2,
        REG_BIG_ENDIAN   = 3'd3,
        REG_SIGNED_VALUE = 3'd4,
        REG_SCALE_FACTOR = 3'd5,
        REG_SCALE_OFFSET = 3'd6
    } reg_idx_t;

    // Incoming frame beat
    typedef struct packed {
        logic [ID_W-1:0]    frame_id;
        logic [DATA_W-1:0]  frame_data;
        logic [COUNT_W-1:0] byte_count;
    } frame_t;

    // Outgoing result beat
    typedef struct packed {
        status_t                    status;
        logic signed [OFFSET_W-1:0] scaled_value;
    } result_t;

    // Configuration register set
    typedef struct packed {
        logic [ID_W-1:0]            message_id;
        logic [START_W-1:0]         sig_start;
        logic [LEN_W-1:0]           bit_length;
        logic                       big_endian;
        logic                       signed_value;
        logic signed [FACTOR_W-1:0] scale_factor;
        logic signed [OFFSET_W-1:0] scale_offset;
    } cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        status_t                 status;
        logic signed [RAW_W-1:0] raw;
    } item_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

// ===== rtl/cansx_front.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - front end
// Accepts frames, checks identifier and signal span, cuts the raw signal
// out of the payload and sign-extends it into one registered item.
// ----------------------------------------------------------------------------
module cansx_front
    import cansx_pkg::*;
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         frame_valid,
    output logic         frame_stall,
    input  frame_t       frame,
    input  queue_flags_t q_flags,
    output logic         push,
    output item_t        item
);

    logic               valid_reg;
    logic               valid_next;
    item_t              item_reg;
    item_t              item_next;

    status_t            status_c;
    logic [LEN_W-1:0]   len_c;
    logic [START_W-1:0] first;
    logic [7:0]         span;
    logic [4:0]         end_bytes;
    logic [COUNT_W-1:0] count_c;
    logic [START_W-1:0] shamt;
    logic [START_W-1:0] sign_pos;
    logic [DATA_W-1:0]  swapped;
    logic [DATA_W-1:0]  src;
    logic [DATA_W-1:0]  field;
    logic [DATA_W-1:0]  mask;
    logic               sign;

    // Byte-swapped payload: Motorola sawtooth order becomes a plain MSB-first word.
    always_comb
    begin
        for (int b = 0; b < DATA_BYTES; b++)
        begin
            swapped[8*b +: 8] = frame.frame_data[8*(DATA_BYTES-1-b) +: 8];
        end
    end

    // Clamp length and byte count, locate the first bit in MSB-first numbering.
    always_comb
    begin
        if (cfg.bit_length == '0)
        begin
            len_c = 7'd1;
        end
        else if (cfg.bit_length > LEN_MAX)
        begin
            len_c = LEN_MAX;
        end
        else
        begin
            len_c = cfg.bit_length;
        end
        if (cfg.big_endian)
        begin
            first = {cfg.sig_start[5:3], ~cfg.sig_start[2:0]};
        end
        else
        begin
            first = cfg.sig_start;
        end
        span      = {2'b00, first} + {1'b0, len_c};
        end_bytes = 5'((span + 8'd7) >> 3);
        if (frame.byte_count > COUNT_W'(FRAME_BYTES))
        begin
            count_c = COUNT_W'(FRAME_BYTES);
        end
        else
        begin
            count_c = frame.byte_count;
        end
    end

    // Classify the frame.
    always_comb
    begin
        if (frame.frame_id != cfg.message_id)
        begin
            status_c = ST_ID_MISMATCH;
        end
        else if (end_bytes > {1'b0, count_c})
        begin
            status_c = ST_BEYOND_FRAME;
        end
        else
        begin
            status_c = ST_OK;
        end
    end

    // One shifter serves both byte orders; the mask keeps the signal bits.
    always_comb
    begin
        if (cfg.big_endian)
        begin
            src   = swapped;
            shamt = START_W'(8'd64 - span);
        end
        else
        begin
            src   = frame.frame_data;
            shamt = first;
        end
        mask     = ~({DATA_W{1'b1}} << len_c);
        field    = (src >> shamt) & mask;
        sign_pos = START_W'(len_c - 7'd1);
        sign     = cfg.signed_value & field[sign_pos];
        item_next.status = status_c;
        item_next.raw    = {sign, (sign ? (field | ~mask) : field)};
    end

    // Output stage: holds while the queue is full.
    assign frame_stall = valid_reg && q_flags.full;
    assign push        = valid_reg && !q_flags.full;
    assign item        = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!frame_stall)
        begin
            valid_next = frame_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && !frame_stall)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/cansx_queue.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cansx_queue
    import cansx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  item_t        push_item,
    input  logic         pop,
    output item_t        head,
    output queue_flags_t flags
);

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    // Flags and head entry
    assign flags.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign flags.empty = (count_reg == '0);
    assign head        = entries_reg[rd_ptr_reg];
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/cansx_back.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - back end
// Multiplies the raw signal by the Q16.16 factor in two partial products,
// adds the Q48.16 offset and saturates into the output register.
// ----------------------------------------------------------------------------
module cansx_back
    import cansx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  item_t        head,
    input  queue_flags_t q_flags,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_stall,
    output result_t      result
);

    logic                   advance;

    logic                   s1_valid_reg;
    status_t                s1_status_reg;
    logic signed [64:0]     s1_plo_reg;
    logic signed [64:0]     s1_plo_next;
    logic signed [32:0]     s1_hi_reg;

    logic                   s2_valid_reg;
    status_t                s2_status_reg;
    logic signed [64:0]     s2_plo_reg;
    logic signed [64:0]     s2_phi_reg;
    logic signed [64:0]     s2_phi_next;

    logic                   s3_valid_reg;
    status_t                s3_status_reg;
    logic signed [96:0]     s3_prod_reg;
    logic signed [96:0]     s3_prod_next;

    logic                   out_valid_reg;
    result_t                out_reg;
    result_t                out_next;
    logic signed [97:0]     sum;
    logic [OFFSET_W-1:0]    sat;

    // Whole pipeline moves unless a finished result is held.
    assign advance = !out_valid_reg || !result_stall;
    assign pop     = advance && !q_flags.empty;

    // Stage 1: low half of the raw value times the factor.
    assign s1_plo_next = $signed({1'b0, head.raw[31:0]}) * cfg.scale_factor;

    // Stage 2: signed high half of the raw value times the factor.
    assign s2_phi_next = s1_hi_reg * cfg.scale_factor;

    // Stage 3: combine the partial products.
    assign s3_prod_next = $signed({s2_phi_reg, 32'b0})
                        + $signed({{32{s2_plo_reg[64]}}, s2_plo_reg});

    // Stage 4: add the offset and saturate to 64 bits.
    always_comb
    begin
        sum = $signed({s3_prod_reg[96], s3_prod_reg})
            + $signed({{34{cfg.scale_offset[63]}}, cfg.scale_offset});
        if (sum[97:63] == {35{sum[97]}})
        begin
            sat = sum[63:0];
        end
        else if (sum[97])
        begin
            sat = {1'b1, {(OFFSET_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(OFFSET_W-1){1'b1}}};
        end
        out_next.status = s3_status_reg;
        if (s3_status_reg == ST_OK)
        begin
            out_next.scaled_value = sat;
        end
        else
        begin
            out_next.scaled_value = '0;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_flags.empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_status_reg <= head.status;
            s1_plo_reg    <= s1_plo_next;
            s1_hi_reg     <= head.raw[64:32];
            s2_status_reg <= s1_status_reg;
            s2_plo_reg    <= s1_plo_reg;
            s2_phi_reg    <= s2_phi_next;
            s3_status_reg <= s2_status_reg;
            s3_prod_reg   <= s3_prod_next;
            out_reg       <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/can_signal_extract_scale_unit.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - top level
// Decodes one configured signal from classic CAN frames and scales it.
//
//   Channel   Direction  Handshake                 Beat
//   frame     in         frame_valid/frame_stall   frame_t  (id, data, count)
//   result    out        result_valid/result_stall result_t (status, value)
//   config    in         APB psel/penable/pwrite   64-bit register, addr 8*i
//
// One frame is accepted per cycle while the front is not stalled; a result
// passes the front register, a queue entry, three multiply stages and the
// output register. Rate is set by the four-stage multiply-add pipeline,
// which takes one item per cycle unless a result is held. The front keeps
// taking frames while the four-entry queue has room, so a stalled result
// holds only the back end at first.
// Reset is immediate; there is no clearing pass.
// ----------------------------------------------------------------------------
module can_signal_extract_scale_unit
    import cansx_pkg::*;
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  frame_t             frame,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    reg_idx_t     reg_idx;
    logic         cfg_write;
    logic         push;
    logic         pop;
    item_t        front_item;
    item_t        head;
    queue_flags_t q_flags;

    // Register decode
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MESSAGE_ID:   cfg_next.message_id   = pwdata[ID_W-1:0];
                REG_SIG_START:    cfg_next.sig_start    = pwdata[START_W-1:0];
                REG_BIT_LENGTH:   cfg_next.bit_length   = pwdata[LEN_W-1:0];
                REG_BIG_ENDIAN:   cfg_next.big_endian   = pwdata[0];
                REG_SIGNED_VALUE: cfg_next.signed_value = pwdata[0];
                REG_SCALE_FACTOR: cfg_next.scale_factor = pwdata[FACTOR_W-1:0];
                REG_SCALE_OFFSET: cfg_next.scale_offset = pwdata[OFFSET_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_MESSAGE_ID:   prdata = PDATA_W'(cfg_reg.message_id);
            REG_SIG_START:    prdata = PDATA_W'(cfg_reg.sig_start);
            REG_BIT_LENGTH:   prdata = PDATA_W'(cfg_reg.bit_length);
            REG_BIG_ENDIAN:   prdata = PDATA_W'(cfg_reg.big_endian);
            REG_SIGNED_VALUE: prdata = PDATA_W'(cfg_reg.signed_value);
            REG_SCALE_FACTOR: prdata = {32'b0, cfg_reg.scale_factor};
            REG_SCALE_OFFSET: prdata = cfg_reg.scale_offset;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.message_id   <= '0;
            cfg_reg.sig_start    <= '0;
            cfg_reg.bit_length   <= 7'd1;
            cfg_reg.big_endian   <= 1'b0;
            cfg_reg.signed_value <= 1'b0;
            cfg_reg.scale_factor <= 32'sd65536;
            cfg_reg.scale_offset <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept and classify
    cansx_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .q_flags     (q_flags),
        .push        (push),
        .item        (front_item)
    );

    // Queue between the two halves
    cansx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .flags     (q_flags)
    );

    // Back end: scale, offset, saturate
    cansx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .q_flags      (q_flags),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/cansx_checker.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - port checker
// Watches the top-level ports for held results, zeroed rejects and the
// cause of input back-pressure.
// ----------------------------------------------------------------------------
module cansx_checker
    import cansx_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    frame_valid,
    input logic    frame_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A stalled result beat stays and holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("result beat changed while stalled");

    // Rejected frames carry a zero value.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.scaled_value == '0))
        else $error("rejected frame carries a nonzero value");

    // Input back-pressure only starts after the output was held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_stall) |-> $past(result_valid && result_stall))
        else $error("frame stall raised without a held result");

    // A frame stall only shows while a frame is offered or held in front.
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> $past(frame_valid || frame_stall))
        else $error("frame stall with no frame in the front stage");

endmodule

bind can_signal_extract_scale_unit cansx_checker u_cansx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== verif/can_signal_extract_scale_unit_tb.sv =====
// ----------------------------------------------------------------------------
// CAN signal extract and scale - unit testbench
// Drives classic CAN frames into the unit and checks every result beat
// against a fixed value or a predictor of the decode and the Q48.16 scaling.
// A short table of directed frames covers identifier mismatch, payload
// overrun, byte counts above eight, odd signal lengths, both byte orders
// and saturation. After that, random frames run under several register
// settings, with the sender idling and the receiver stalling in turn.
// ----------------------------------------------------------------------------
module can_signal_extract_scale_unit_tb;
    import cansx_pkg::*;

    localparam int FRAME_BYTES = DATA_BYTES;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES = 110;
    localparam int DIR_ROWS = 22;

    // One directed row: register setting, frame, and an optional fixed result
    typedef struct packed {
        cfg_t    cfg;
        frame_t  frm;
        logic    typed;
        result_t want;
    } vector_t;

    localparam cfg_t CFG_RESET = '{
        message_id: 29'h0, sig_start: 6'd0, bit_length: 7'd1, big_endian: 1'b0,
        signed_value: 1'b0, scale_factor: 32'sh0001_0000, scale_offset: 64'sh0};
    localparam cfg_t CFG_TOP = '{
        message_id: 29'h1FFF_FFFF, sig_start: 6'd63, bit_length: 7'd1, big_endian: 1'b0,
        signed_value: 1'b0, scale_factor: 32'shFFFF_0000, scale_offset: 64'sh0};
    localparam cfg_t CFG_MOTO16 = '{
        message_id: 29'h123, sig_start: 6'd7, bit_length: 7'd16, big_endian: 1'b1,
        signed_value: 1'b1, scale_factor: 32'sh0001_8000,
        scale_offset: 64'shFFFF_FFFF_FFFB_0000};
    localparam cfg_t CFG_MOTO57 = '{
        message_id: 29'h7FF, sig_start: 6'd0, bit_length: 7'd57, big_endian: 1'b1,
        signed_value: 1'b0, scale_factor: 32'sh0001_0000, scale_offset: 64'sh8000};
    localparam cfg_t CFG_LEN0 = '{
        message_id: 29'h0A5A_5A5A, sig_start: 6'd5, bit_length: 7'd0, big_endian: 1'b0,
        signed_value: 1'b0, scale_factor: 32'sh8000_0000,
        scale_offset: 64'sh7FFF_FFFF_FFFF_FFFF};
    localparam cfg_t CFG_LEN100 = '{
        message_id: 29'h1555_5555, sig_start: 6'd0, bit_length: 7'd100, big_endian: 1'b0,
        signed_value: 1'b1, scale_factor: 32'sh7FFF_FFFF,
        scale_offset: 64'sh8000_0000_0000_0000};
    localparam cfg_t CFG_U64 = '{
        message_id: 29'h1555_5555, sig_start: 6'd0, bit_length: 7'd64, big_endian: 1'b0,
        signed_value: 1'b0, scale_factor: 32'sh8000_0000,
        scale_offset: 64'sh7FFF_FFFF_FFFF_FFFF};
    localparam cfg_t CFG_S64 = '{
        message_id: 29'h1555_5555, sig_start: 6'd0, bit_length: 7'd64, big_endian: 1'b0,
        signed_value: 1'b1, scale_factor: 32'sh0001_0000, scale_offset: 64'sh0};

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VMIN = 64'h8000_0000_0000_0000;

    // Rows with typed = 0 are checked against the predictor
    localparam vector_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{CFG_RESET,  '{29'h1FFF_FFFF, 64'h0, 4'd8}, 1'b1, '{ST_ID_MISMATCH, 64'sh0}},
        '{CFG_RESET,  '{29'h0, ONES, 4'd0},          1'b1, '{ST_BEYOND_FRAME, 64'sh0}},
        '{CFG_RESET,  '{29'h0, 64'h1, 4'd1},         1'b1, '{ST_OK, 64'sh1_0000}},
        '{CFG_RESET,  '{29'h0, ONES - 64'h1, 4'd15}, 1'b1, '{ST_OK, 64'sh0}},
        '{CFG_RESET,  '{29'h0, ONES, 4'd8},          1'b1, '{ST_OK, 64'sh1_0000}},
        '{CFG_TOP,    '{29'h1FFF_FFFF, VMIN, 4'd8},  1'b0, '{ST_OK, 64'sh0}},
        '{CFG_TOP,    '{29'h1FFF_FFFF, ONES, 4'd7},  1'b1, '{ST_BEYOND_FRAME, 64'sh0}},
        '{CFG_TOP,    '{29'h0, ONES, 4'd8},          1'b1, '{ST_ID_MISMATCH, 64'sh0}},
        '{CFG_MOTO16, '{29'h123, 64'h3412, 4'd2},    1'b0, '{ST_OK, 64'sh0}},
        '{CFG_MOTO16, '{29'h123, ONES, 4'd1},        1'b1, '{ST_BEYOND_FRAME, 64'sh0}},
        '{CFG_MOTO16, '{29'h123, 64'hCD9A, 4'd8},    1'b0, '{ST_OK, 64'sh0}},
        '{CFG_MOTO57, '{29'h7FF, 64'hA5C3_5A3C_0FF0_9669, 4'd8}, 1'b0, '{ST_OK, 64'sh0}},
        '{CFG_MOTO57, '{29'h7FF, 64'hA5C3_5A3C_0FF0_9669, 4'd7}, 1'b1,
            '{ST_BEYOND_FRAME, 64'sh0}},
        '{CFG_LEN0,   '{29'h0A5A_5A5A, 64'h20, 4'd1}, 1'b0, '{ST_OK, 64'sh0}},
        '{CFG_LEN0,   '{29'h0A5A_5A5A, ONES ^ 64'h20, 4'd8}, 1'b1, '{ST_OK, VMAX}},
        '{CFG_LEN100, '{29'h1555_5555, VMIN, 4'd8},  1'b1, '{ST_OK, VMIN}},
        '{CFG_LEN100, '{29'h1555_5555, VMAX, 4'd8},  1'b1, '{ST_OK, VMAX}},
        '{CFG_LEN100, '{29'h1555_5555, ONES, 4'd8},  1'b1, '{ST_OK, VMIN}},
        '{CFG_U64,    '{29'h1555_5555, ONES, 4'd8},  1'b1, '{ST_OK, VMIN}},
        '{CFG_U64,    '{29'h1555_5555, 64'h1, 4'd8}, 1'b0, '{ST_OK, 64'sh0}},
        '{CFG_S64,    '{29'h1555_5555, 64'hFEDC_BA98_7654_3210, 4'd8}, 1'b0, '{ST_OK, 64'sh0}},
        '{CFG_S64,    '{29'h1555_5555, 64'hFEDC_BA98_7654_3210, 4'd7}, 1'b1,
            '{ST_BEYOND_FRAME, 64'sh0}}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               frame_valid;
    logic               frame_stall;
    frame_t             frame;
    logic               result_valid;
    logic               result_stall;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Sideband that travels with the frame beat: a fixed expectation
    logic               row_typed;
    result_t            row_want;

    cfg_t               cur_cfg;
    result_t            decoded_queue[$];
    result_t            want_now;
    int unsigned        gap_pct;
    int unsigned        stall_pct;
    int unsigned        idle_cycles;
    int unsigned        n_errors;
    int unsigned        n_frames;
    int unsigned        n_results;
    int unsigned        n_settings;
    int unsigned        n_ok;
    int unsigned        n_sat;
    int unsigned        n_id_miss;
    int unsigned        n_beyond;

    can_signal_extract_scale_unit #(
        .FRAME_BYTES (FRAME_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Signal length after clamping to 1..64
    function automatic int unsigned sig_len(cfg_t c);
        if (c.bit_length == '0)
            return 1;
        if (c.bit_length > LEN_MAX)
            return 64;
        return c.bit_length;
    endfunction

    // Position of the signal's first bit; Motorola counts MSB first
    function automatic int unsigned sig_first(cfg_t c);
        int unsigned sb;
        sb = c.sig_start;
        return c.big_endian ? (sb / 8) * 8 + 7 - sb % 8 : sb;
    endfunction

    // Predicted result beat for one frame under setting c
    function automatic result_t decode_signal(cfg_t c, frame_t f);
        int unsigned         len;
        int unsigned         first;
        int unsigned         cnt;
        int unsigned         idx;
        int unsigned         i;
        logic [63:0]         raw;
        logic signed [127:0] wide_raw;
        logic signed [127:0] wide_fac;
        logic signed [127:0] wide_off;
        logic signed [127:0] total;
        result_t             r;
        r.status = ST_OK;
        r.scaled_value = '0;
        len = sig_len(c);
        first = sig_first(c);
        cnt = (f.byte_count > FRAME_BYTES) ? FRAME_BYTES : f.byte_count;
        if (f.frame_id != c.message_id)
        begin
            r.status = ST_ID_MISMATCH;
            return r;
        end
        if ((first + len + 7) / 8 > cnt)
        begin
            r.status = ST_BEYOND_FRAME;
            return r;
        end

        // Cut the field out of the payload
        raw = '0;
        if (c.big_endian)
        begin
            for (i = 0; i < len; i++)
            begin
                idx = first + i;
                raw = {raw[62:0], f.frame_data[(idx / 8) * 8 + 7 - idx % 8]};
            end
        end
        else
        begin
            raw = f.frame_data >> first;
            if (len < 64)
                raw &= (64'h1 << len) - 64'h1;
        end

        // Sign-extend, then multiply and add exactly in 128 bits
        if (c.signed_value && raw[len - 1])
        begin
            if (len < 64)
                raw |= ~((64'h1 << len) - 64'h1);
            wide_raw = {{64{1'b1}}, raw};
        end
        else
        begin
            wide_raw = {64'h0, raw};
        end
        wide_fac = {{96{c.scale_factor[31]}}, c.scale_factor};
        wide_off = {{64{c.scale_offset[63]}}, c.scale_offset};
        total = wide_raw * wide_fac + wide_off;

        // Saturate to the signed 64-bit range
        if (total[127:63] == {65{total[63]}})
            r.scaled_value = total[63:0];
        else if (total[127])
            r.scaled_value = VMIN;
        else
            r.scaled_value = VMAX;
        return r;
    endfunction

    // Random register setting, mostly one whose signal fits in eight bytes
    function automatic cfg_t pick_config();
        cfg_t        c;
        int unsigned len;
        int unsigned first;
        c.message_id = ($urandom_range(3) == 0) ? {ID_W{1'b1}} : ID_W'($urandom);
        len = ($urandom_range(1) == 1) ? $urandom_range(16, 1) : $urandom_range(64, 1);
        first = $urandom_range(64 - len, 0);
        c.big_endian = 1'($urandom_range(1));
        c.sig_start = START_W'(c.big_endian ? (first / 8) * 8 + 7 - first % 8 : first);
        if ($urandom_range(7) == 0)
            c.sig_start = START_W'($urandom);
        c.bit_length = LEN_W'(len);
        case ($urandom_range(11))
            0: c.bit_length = '0;
            1: c.bit_length = LEN_W'($urandom_range(127, 65));
            default: ;
        endcase
        c.signed_value = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: c.scale_factor = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1:
            begin
                c.scale_factor = $urandom_range(32'h0003_0000);
                if ($urandom_range(1) == 1)
                    c.scale_factor = -c.scale_factor;
            end
            default: c.scale_factor = $urandom;
        endcase
        case ($urandom_range(3))
            0: c.scale_offset = ($urandom_range(1) == 1) ? VMAX : VMIN;
            1:
            begin
                c.scale_offset = {32'h0, $urandom};
                if ($urandom_range(1) == 1)
                    c.scale_offset = -c.scale_offset;
            end
            default: c.scale_offset = {$urandom, $urandom};
        endcase
        return c;
    endfunction

    // Random frame, mostly addressed to the signal with enough bytes
    function automatic frame_t pick_frame(cfg_t c);
        frame_t      f;
        int unsigned need;
        need = (sig_first(c) + sig_len(c) + 7) / 8;
        f.frame_id = ($urandom_range(9) < 8) ? c.message_id : ID_W'($urandom);
        case ($urandom_range(15))
            0: f.frame_data = '0;
            1: f.frame_data = ONES;
            default: f.frame_data = {$urandom, $urandom};
        endcase
        case ($urandom_range(9))
            0: f.byte_count = COUNT_W'($urandom);
            1: f.byte_count = COUNT_W'($urandom_range(15, FRAME_BYTES + 1));
            default:
                f.byte_count = COUNT_W'((need <= FRAME_BYTES) ?
                    $urandom_range(FRAME_BYTES, need) : $urandom_range(FRAME_BYTES));
        endcase
        return f;
    endfunction

    task automatic log_mismatch(string what, result_t want, result_t got);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR result %0d: %s: expected status %0d value %h, got status %0d value %h",
                     n_results, what, want.status, want.scaled_value,
                     got.status, got.scaled_value);
    endtask

    // Offer one frame beat, idling first at random, and wait until it is taken
    task automatic send_frame(frame_t f, logic typed, result_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame       <= f;
        row_typed   <= typed;
        row_want    <= want;
        frame_valid <= 1'b1;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic wait_drained();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (decoded_queue.size() != 0)
            @(posedge clk);
    endtask

    // One register write: setup cycle, then access until pready
    task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write the registers that differ from the current setting
    task automatic apply_config(cfg_t c);
        if (c.message_id != cur_cfg.message_id)
            reg_write(REG_MESSAGE_ID, PDATA_W'(c.message_id));
        if (c.sig_start != cur_cfg.sig_start)
            reg_write(REG_SIG_START, PDATA_W'(c.sig_start));
        if (c.bit_length != cur_cfg.bit_length)
            reg_write(REG_BIT_LENGTH, PDATA_W'(c.bit_length));
        if (c.big_endian != cur_cfg.big_endian)
            reg_write(REG_BIG_ENDIAN, PDATA_W'(c.big_endian));
        if (c.signed_value != cur_cfg.signed_value)
            reg_write(REG_SIGNED_VALUE, PDATA_W'(c.signed_value));
        if (c.scale_factor != cur_cfg.scale_factor)
            reg_write(REG_SCALE_FACTOR, {32'h0, c.scale_factor});
        if (c.scale_offset != cur_cfg.scale_offset)
            reg_write(REG_SCALE_OFFSET, c.scale_offset);
        cur_cfg = c;
        n_settings++;
    endtask

    // Receiver stall pattern
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // Result check first, then prediction of the frame taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (decoded_queue.size() == 0)
                begin
                    log_mismatch("unexpected beat", '0, result);
                end
                else
                begin
                    want_now = decoded_queue.pop_front();
                    if (result.status !== want_now.status ||
                        result.scaled_value !== want_now.scaled_value)
                        log_mismatch("field mismatch", want_now, result);
                end
            end
            if (frame_valid && !frame_stall)
            begin
                want_now = row_typed ? row_want : decode_signal(cur_cfg, frame);
                decoded_queue.push_back(want_now);
                n_frames++;
                case (want_now.status)
                    ST_OK:
                    begin
                        n_ok++;
                        if (want_now.scaled_value == VMAX || want_now.scaled_value == VMIN)
                            n_sat++;
                    end
                    ST_ID_MISMATCH: n_id_miss++;
                    default: n_beyond++;
                endcase
            end

            // Watchdog on beats in either direction
            if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no beat accepted for %0d cycles, %0d results outstanding",
                         idle_cycles, decoded_queue.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int row_i;
        int phase;
        int k;
        rst_n        = 1'b0;
        frame_valid  = 1'b0;
        frame        = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        idle_cycles  = 0;
        n_errors     = 0;
        n_frames     = 0;
        n_results    = 0;
        n_settings   = 1;
        n_ok         = 0;
        n_sat        = 0;
        n_id_miss    = 0;
        n_beyond     = 0;
        cur_cfg      = CFG_RESET;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, starting from the reset setting
        for (row_i = 0; row_i < DIR_ROWS; row_i++)
        begin
            if (DIR_TAB[row_i].cfg != cur_cfg)
            begin
                wait_drained();
                apply_config(DIR_TAB[row_i].cfg);
            end
            send_frame(DIR_TAB[row_i].frm, DIR_TAB[row_i].typed, DIR_TAB[row_i].want);
        end

        // Random frames; each phase gets a new setting and idling pattern
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 57; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 57; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            wait_drained();
            apply_config(pick_config());
            for (k = 0; k < PHASE_FRAMES; k++)
            begin
                // Hold the sender back once until the results have all come
                if (phase == 2 && k == PHASE_FRAMES / 2)
                    wait_drained();
                send_frame(pick_frame(cur_cfg), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20)
            @(posedge clk);

        $display("Covered %0d frames under %0d register settings: %0d decoded (%0d saturated),",
                 n_frames, n_settings, n_ok, n_sat);
        $display("%0d identifier mismatches, %0d signals past the payload, %0d errors.",
                 n_id_miss, n_beyond, n_errors);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
